>>> rtl/core/three_channel_boxcar_monitor_top_defines.svh
// Assertion macros for the three-channel boxcar monitor.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef THREE_CHANNEL_BOXCAR_MONITOR_TOP_DEFINES_SVH
`define THREE_CHANNEL_BOXCAR_MONITOR_TOP_DEFINES_SVH

`define BCM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define BCM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/bcm_pkg.sv
// Shared widths, register map and reset values for the boxcar monitor.
// No dependencies; used by bcm_window, the top level and the simulation files.
package bcm_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int GAIN_C_W  = 16;
  localparam int GAIN_V_W  = 6;
  localparam int OFFSET_W  = 12;
  localparam int CUR_W     = 12;
  localparam int VOLT_W    = 18;
  localparam int TEMP_W    = 13;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] RegCurrentGain = 2'd0;
  localparam logic [REG_IDX_W-1:0] RegVoltageGain = 2'd1;
  localparam logic [REG_IDX_W-1:0] RegTempOffset  = 2'd2;

  localparam logic [GAIN_C_W-1:0] GAIN_C_RST = 16'd27223;
  localparam logic [GAIN_V_W-1:0] GAIN_V_RST = 6'd11;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd500;

endpackage

>>> rtl/core/bcm_window.sv
// One channel of sample history: ring memory, per-entry valid bits and running sum.
// Depends on bcm_pkg; instantiated once per channel by the top level.
module bcm_window #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             wr_en_i,
  input  logic [$clog2(WINDOW_LEN)-1:0]                    pos_i,
  input  logic [$clog2(WINDOW_LEN)-1:0]                    pos_nxt_i,
  input  logic [bcm_pkg::SAMPLE_W-1:0]                     sample_i,
  output logic [bcm_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0]  sum_o
);

  localparam int SUM_W = bcm_pkg::SAMPLE_W + $clog2(WINDOW_LEN);

  logic [bcm_pkg::SAMPLE_W-1:0] mem_q [WINDOW_LEN];
  logic [bcm_pkg::SAMPLE_W-1:0] rd_q;
  logic [bcm_pkg::SAMPLE_W-1:0] old_smp;
  logic [WINDOW_LEN-1:0]        vld_q;
  logic [SUM_W-1:0]             sum_q;
  logic [SUM_W-1:0]             sum_d;

  // prefetch the entry at the next write position
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[pos_i] <= sample_i;
    end
    rd_q <= mem_q[pos_nxt_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      sum_q <= '0;
    end else if (wr_en_i) begin
      vld_q[pos_i] <= 1'b1;
      sum_q        <= sum_d;
    end
  end

  always_comb begin
    old_smp = vld_q[pos_i] ? rd_q : '0;
    sum_d   = sum_q - SUM_W'(old_smp) + SUM_W'(sample_i);
  end

  assign sum_o = sum_q;

endmodule

>>> rtl/core/three_channel_boxcar_monitor_top.sv
// Three-channel boxcar monitor: current, supply voltage and temperature.
//
// Input stream (s_axis): one request carries a 12-bit mV sample per channel.
// Output stream (m_axis): one result per request with the boxcar averages over
// the last WINDOW_LEN samples and the newest samples, converted to mA, supply mV
// and tenths of a degree. Averages always divide by WINDOW_LEN; history entries
// not yet written count as zero.
// APB port: current gain (Q0.16) at 0x0, voltage gain at 0x4, temperature
// offset at 0x8. Write registers only while the block is idle.
// Pipeline: a result passes three registers after its request is accepted:
// running-sum update, reciprocal multiply for the average, unit conversion.
// Throughput: one request per cycle while m_axis does not stall, bounded by the
// per-channel ring read-modify-write, which completes in the accepting cycle.
// Reset clears history, sums, pipeline and loads default gains and offset.
// When m_axis stalls, the three stages fill and s_axis_tready drops only when
// all of them hold data. Depends on bcm_pkg, bcm_window and the defines header.
`include "three_channel_boxcar_monitor_top_defines.svh"

module three_channel_boxcar_monitor_top #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // current_sample_mv, voltage_sample_mv, temp_sample_mv, zero pad
  input  logic [39:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // avg_current_ma, avg_voltage_mv, avg_temp_decidegrees, last_current_ma,
  // last_voltage_mv, last_temp_decidegrees, zero pad
  output logic [87:0]                  m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcm_pkg::APB_AW-1:0]   paddr,
  input  logic [bcm_pkg::APB_DW-1:0]   pwdata,
  output logic [bcm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int SW      = bcm_pkg::SAMPLE_W;
  localparam int POS_W   = $clog2(WINDOW_LEN);
  localparam int SUM_W   = SW + POS_W;
  localparam int DIV_SH  = SUM_W + POS_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

  // configuration
  logic [bcm_pkg::GAIN_C_W-1:0]  gain_c_q;
  logic [bcm_pkg::GAIN_V_W-1:0]  gain_v_q;
  logic [bcm_pkg::OFFSET_W-1:0]  offset_q;
  logic [bcm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  // pipeline
  logic             s_acc;
  logic             out_rdy, s2_rdy, s1_rdy;
  logic             s1_v_q, s2_v_q, out_v_q;
  logic [POS_W-1:0] pos_q, pos_nxt;
  logic [SW-1:0]    in_smp [3];
  logic [SUM_W-1:0] sum [3];
  logic [SW-1:0]    s1_smp_q [3];
  logic [SW-1:0]    avg_d [3];
  logic [SW-1:0]    s2_avg_q [3];
  logic [SW-1:0]    s2_smp_q [3];
  logic [87:0]      out_d, out_q;

  function automatic logic [bcm_pkg::CUR_W-1:0] conv_cur(
    input logic [SW-1:0] x, input logic [bcm_pkg::GAIN_C_W-1:0] g);
    logic [SW+bcm_pkg::GAIN_C_W-1:0] p;
    p = (SW+bcm_pkg::GAIN_C_W)'(x) * (SW+bcm_pkg::GAIN_C_W)'(g);
    return p[bcm_pkg::GAIN_C_W +: bcm_pkg::CUR_W];
  endfunction

  function automatic logic [bcm_pkg::VOLT_W-1:0] conv_volt(
    input logic [SW-1:0] x, input logic [bcm_pkg::GAIN_V_W-1:0] g);
    return bcm_pkg::VOLT_W'(x) * bcm_pkg::VOLT_W'(g);
  endfunction

  function automatic logic [bcm_pkg::TEMP_W-1:0] conv_temp(
    input logic [SW-1:0] x, input logic [bcm_pkg::OFFSET_W-1:0] off);
    return bcm_pkg::TEMP_W'(x) - bcm_pkg::TEMP_W'(off);
  endfunction

  // APB registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[bcm_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_c_q <= bcm_pkg::GAIN_C_RST;
      gain_v_q <= bcm_pkg::GAIN_V_RST;
      offset_q <= bcm_pkg::OFFSET_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bcm_pkg::RegCurrentGain: gain_c_q <= pwdata[bcm_pkg::GAIN_C_W-1:0];
        bcm_pkg::RegVoltageGain: gain_v_q <= pwdata[bcm_pkg::GAIN_V_W-1:0];
        bcm_pkg::RegTempOffset:  offset_q <= pwdata[bcm_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bcm_pkg::RegCurrentGain: prdata = bcm_pkg::APB_DW'(gain_c_q);
      bcm_pkg::RegVoltageGain: prdata = bcm_pkg::APB_DW'(gain_v_q);
      bcm_pkg::RegTempOffset:  prdata = bcm_pkg::APB_DW'(offset_q);
      default:                 prdata = '0;
    endcase
  end

  // handshake and stage enables
  assign out_rdy       = !out_v_q || m_axis_tready;
  assign s2_rdy        = !s2_v_q || out_rdy;
  assign s1_rdy        = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;
  assign s_acc         = s_axis_tvalid && s1_rdy;

  assign in_smp[0] = s_axis_tdata[SW-1:0];
  assign in_smp[1] = s_axis_tdata[2*SW-1:SW];
  assign in_smp[2] = s_axis_tdata[3*SW-1:2*SW];

  assign pos_nxt = !s_acc ? pos_q : ((pos_q == POS_LAST) ? '0 : pos_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      pos_q <= pos_nxt;
      if (s1_rdy) begin
        s1_v_q <= s_axis_tvalid;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    bcm_window #(
      .WINDOW_LEN(WINDOW_LEN)
    ) u_window (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (s_acc),
      .pos_i     (pos_q),
      .pos_nxt_i (pos_nxt),
      .sample_i  (in_smp[ch]),
      .sum_o     (sum[ch])
    );

    // divide by WINDOW_LEN via a rounded-up reciprocal that gives the exact quotient
    logic [PROD_W-1:0] prod;
    assign prod      = PROD_W'(sum[ch]) * PROD_W'(RECIP);
    assign avg_d[ch] = prod[DIV_SH +: SW];

    always_ff @(posedge clk_i) begin
      if (s_acc) begin
        s1_smp_q[ch] <= in_smp[ch];
      end
      if (s2_rdy && s1_v_q) begin
        s2_avg_q[ch] <= avg_d[ch];
        s2_smp_q[ch] <= s1_smp_q[ch];
      end
    end
  end

  assign out_d = {2'b00,
                  conv_temp(s2_smp_q[2], offset_q),
                  conv_volt(s2_smp_q[1], gain_v_q),
                  conv_cur(s2_smp_q[0], gain_c_q),
                  conv_temp(s2_avg_q[2], offset_q),
                  conv_volt(s2_avg_q[1], gain_v_q),
                  conv_cur(s2_avg_q[0], gain_c_q)};

  always_ff @(posedge clk_i) begin
    if (out_rdy && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `BCM_ASSERT_ALWAYS(a_pos_range, pos_q <= POS_LAST, "write position out of range")
  `BCM_ASSERT_ALWAYS(a_stall_full, s_axis_tready || (s1_v_q && s2_v_q && out_v_q),
                     "input stalled with a free stage")
  `BCM_ASSERT_NEXT(a_acc_fills, s_acc, s1_v_q, "accepted request lost at stage one")
  `BCM_ASSERT_NEXT(a_pos_adv, s_acc, pos_q == $past(pos_nxt), "position did not advance")
  `BCM_ASSERT_NEXT(a_pos_hold, !s_acc, $stable(pos_q), "position moved without a request")

endmodule

>>> sim/boxcar_reading_checker.sv
`timescale 1ns / 100ps
// Reading checker for the three-channel boxcar monitor: tracks register writes,
// predicts averaged and newest readings per request and compares each result.
// Depends on bcm_pkg for register indexes, widths and reset values.
module boxcar_reading_checker #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [87:0]                  m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcm_pkg::APB_AW-1:0]   paddr,
  input  logic [bcm_pkg::APB_DW-1:0]   pwdata,
  input  logic                         pready,
  output int                           mismatches_o,
  output int                           readings_due_o
);

  typedef struct {
    logic [bcm_pkg::CUR_W-1:0]         avg_current_ma;
    logic [bcm_pkg::VOLT_W-1:0]        avg_voltage_mv;
    logic signed [bcm_pkg::TEMP_W-1:0] avg_temp_dc;
    logic [bcm_pkg::CUR_W-1:0]         last_current_ma;
    logic [bcm_pkg::VOLT_W-1:0]        last_voltage_mv;
    logic signed [bcm_pkg::TEMP_W-1:0] last_temp_dc;
  } reading_t;

  logic [bcm_pkg::GAIN_C_W-1:0] current_gain;
  logic [bcm_pkg::GAIN_V_W-1:0] voltage_gain;
  logic [bcm_pkg::OFFSET_W-1:0] temp_offset;
  logic [bcm_pkg::SAMPLE_W-1:0] history [3][WINDOW_LEN];
  int                           window_sum [3];
  int                           slot;
  reading_t                     readings_due_q [$];

  function automatic logic [bcm_pkg::CUR_W-1:0] to_milliamps(input int mv);
    int ma;
    ma = (mv * int'(current_gain)) >>> 16;
    if (ma > 4095) ma = 4095;
    return ma[bcm_pkg::CUR_W-1:0];
  endfunction

  function automatic logic [bcm_pkg::VOLT_W-1:0] to_supply_mv(input int mv);
    int supply;
    supply = mv * int'(voltage_gain);
    if (supply > 262143) supply = 262143;
    return supply[bcm_pkg::VOLT_W-1:0];
  endfunction

  function automatic logic signed [bcm_pkg::TEMP_W-1:0] to_decidegrees(input int mv);
    int dc;
    dc = mv - int'(temp_offset);
    if (dc > 4095) dc = 4095;
    if (dc < -4095) dc = -4095;
    return dc[bcm_pkg::TEMP_W-1:0];
  endfunction

  task automatic note_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [bcm_pkg::SAMPLE_W-1:0] sample [3];
    int                           average [3];
    reading_t                     want;
    reading_t                     got;
    if (!rst_ni) begin
      current_gain = bcm_pkg::GAIN_C_RST;
      voltage_gain = bcm_pkg::GAIN_V_RST;
      temp_offset  = bcm_pkg::OFFSET_RST;
      for (int ch = 0; ch < 3; ch++) begin
        window_sum[ch] = 0;
        for (int i = 0; i < WINDOW_LEN; i++) history[ch][i] = '0;
      end
      slot = 0;
      readings_due_q.delete();
      mismatches_o = 0;
      readings_due_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {bcm_pkg::RegCurrentGain, 2'b00}: current_gain = pwdata[bcm_pkg::GAIN_C_W-1:0];
          {bcm_pkg::RegVoltageGain, 2'b00}: voltage_gain = pwdata[bcm_pkg::GAIN_V_W-1:0];
          {bcm_pkg::RegTempOffset, 2'b00}:  temp_offset  = pwdata[bcm_pkg::OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sample[0] = s_axis_tdata[11:0];
        sample[1] = s_axis_tdata[23:12];
        sample[2] = s_axis_tdata[35:24];
        for (int ch = 0; ch < 3; ch++) begin
          window_sum[ch] = window_sum[ch] - int'(history[ch][slot]) + int'(sample[ch]);
          history[ch][slot] = sample[ch];
          average[ch] = window_sum[ch] / WINDOW_LEN;
        end
        slot = (slot + 1) % WINDOW_LEN;
        want.avg_current_ma  = to_milliamps(average[0]);
        want.avg_voltage_mv  = to_supply_mv(average[1]);
        want.avg_temp_dc     = to_decidegrees(average[2]);
        want.last_current_ma = to_milliamps(int'(sample[0]));
        want.last_voltage_mv = to_supply_mv(int'(sample[1]));
        want.last_temp_dc    = to_decidegrees(int'(sample[2]));
        readings_due_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.avg_current_ma  = m_axis_tdata[11:0];
        got.avg_voltage_mv  = m_axis_tdata[29:12];
        got.avg_temp_dc     = m_axis_tdata[42:30];
        got.last_current_ma = m_axis_tdata[54:43];
        got.last_voltage_mv = m_axis_tdata[72:55];
        got.last_temp_dc    = m_axis_tdata[85:73];
        if (readings_due_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t result with no request pending: %h", $realtime, m_axis_tdata);
        end else begin
          want = readings_due_q.pop_front();
          note_field("avg_current_ma", want.avg_current_ma, got.avg_current_ma);
          note_field("avg_voltage_mv", want.avg_voltage_mv, got.avg_voltage_mv);
          note_field("avg_temp_decidegrees", want.avg_temp_dc, got.avg_temp_dc);
          note_field("last_current_ma", want.last_current_ma, got.last_current_ma);
          note_field("last_voltage_mv", want.last_voltage_mv, got.last_voltage_mv);
          note_field("last_temp_decidegrees", want.last_temp_dc, got.last_temp_dc);
        end
      end
      readings_due_o = readings_due_q.size();
    end
  end

endmodule

>>> sim/three_channel_boxcar_monitor_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the three-channel boxcar monitor: drives sample requests,
// receiver stalls and APB register writes; the verdict comes from
// boxcar_reading_checker. Depends on bcm_pkg and the monitor RTL.
module three_channel_boxcar_monitor_top_tb;

  localparam int WINDOW_LEN  = 16;
  localparam int HOLD_CYCLES = 200;
  localparam logic [bcm_pkg::REG_IDX_W-1:0] RegSpare = 2'd3;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  // current_sample_mv, voltage_sample_mv, temp_sample_mv, zero pad
  logic [39:0]                 s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  // avg_current_ma, avg_voltage_mv, avg_temp_decidegrees, last_current_ma,
  // last_voltage_mv, last_temp_decidegrees, zero pad
  logic [87:0]                 m_axis_tdata;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bcm_pkg::APB_AW-1:0]  paddr;
  logic [bcm_pkg::APB_DW-1:0]  pwdata;
  logic [bcm_pkg::APB_DW-1:0]  prdata;
  logic                        pready;
  int                          mismatches;
  int                          readings_due;
  bit                          steady_run;
  bit                          rx_hold_req;

  three_channel_boxcar_monitor_top #(.WINDOW_LEN(WINDOW_LEN)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  boxcar_reading_checker #(.WINDOW_LEN(WINDOW_LEN)) reading_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches_o(mismatches), .readings_due_o(readings_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (steady_run) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 21);
      end
    end
  end

  function automatic logic [11:0] pick_mv();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'($urandom_range(63));
      default: return 12'($urandom());
    endcase
  endfunction

  // enter and leave at a falling edge
  task automatic send_request(input logic [11:0] cur, input logic [11:0] volt,
                              input logic [11:0] temp);
    while (!steady_run && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, temp, volt, cur};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (readings_due != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [bcm_pkg::REG_IDX_W-1:0] idx,
                                input int unsigned value, input int width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() << width) | value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_settings(input int unsigned cur_gain, input int unsigned volt_gain,
                               input int unsigned offset);
    write_register(bcm_pkg::RegCurrentGain, cur_gain, bcm_pkg::GAIN_C_W);
    write_register(bcm_pkg::RegVoltageGain, volt_gain, bcm_pkg::GAIN_V_W);
    write_register(bcm_pkg::RegTempOffset, offset, bcm_pkg::OFFSET_W);
  endtask

  initial begin
    int          run_left;
    logic [11:0] held_cur;
    logic [11:0] held_volt;
    logic [11:0] held_temp;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    steady_run    = 1'b0;
    rx_hold_req   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // warm-up at reset settings
    send_request(12'd0, 12'd0, 12'd0);
    send_request(12'hFFF, 12'hFFF, 12'hFFF);
    send_request(12'hFFF, 12'hFFF, 12'hFFF);
    send_request(12'hAAA, 12'h555, 12'hAAA);
    send_request(12'h555, 12'hAAA, 12'h555);
    send_request(12'd1, 12'd1, 12'd0);
    send_request(12'd500, 12'd500, 12'd500);
    send_request(12'hFFF, 12'hFFF, 12'd499);

    drain_results();
    load_settings(0, 0, 0);
    write_register(RegSpare, 32'hFFFF, 16);
    send_request(12'hFFF, 12'hFFF, 12'hFFF);
    send_request(12'd0, 12'd0, 12'd0);

    drain_results();
    load_settings(16'hFFFF, 6'h3F, 12'hFFF);
    send_request(12'hFFF, 12'hFFF, 12'hFFF);
    send_request(12'd0, 12'd0, 12'd0);
    send_request(12'hFFF, 12'hFFF, 12'd0);

    drain_results();
    load_settings(16'hFFFF, 6'h3F, 0);
    send_request(12'hFFF, 12'hFFF, 12'hFFF);
    send_request(12'hFFF, 12'hFFF, 12'hFFF);

    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      case ($urandom_range(3))
        0: load_settings(16'hFFFF, 6'h3F, $urandom_range(4095));
        1: load_settings($urandom_range(15), $urandom_range(3), 12'hFFF);
        default: load_settings($urandom_range(65535), $urandom_range(63), $urandom_range(4095));
      endcase
      if ($urandom_range(1)) write_register(RegSpare, $urandom_range(4095), 12);
      steady_run = (phase == 2);
      if (phase == 5) rx_hold_req = 1'b1;
      run_left = 0;
      for (int n = 0; n < 250; n++) begin
        // hold one triple long enough to fill the window
        if (run_left == 0 && $urandom_range(7) == 0) begin
          run_left  = $urandom_range(17, 40);
          held_cur  = pick_mv();
          held_volt = pick_mv();
          held_temp = pick_mv();
        end
        if (run_left > 0) begin
          run_left--;
          send_request(held_cur, held_volt, held_temp);
        end else begin
          send_request(pick_mv(), pick_mv(), pick_mv());
        end
      end
    end
    steady_run = 1'b0;

    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
